>>> hw/rtl/wpncm_pkg.sv
`default_nettype none

package wpncm_pkg;

    localparam int NUM_CH    = 3;
    localparam int SUM_W     = 32;
    localparam int WGT_W     = 24;
    localparam int OUT_W     = 32;
    localparam int COEF_W    = 18;
    localparam int ROW_W     = NUM_CH * COEF_W;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W      = NUM_CH * SUM_W + WGT_W;
    localparam int OUT_BUS_W = NUM_CH * OUT_W;

    // Quotient bits of the normalize divider, resolved a few per stage
    localparam int QUO_W           = 32;
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

    localparam int PROD_W   = COEF_W + SUM_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int FRAC_SH  = 14;
    localparam int SHIFT_W  = ACC_W - FRAC_SH;

    // Pipeline stage positions
    localparam int ST_IN      = 0;
    localparam int ST_PREP    = 1;
    localparam int ST_CH      = ST_PREP + DIV_STAGES + 1;
    localparam int ST_MUL     = ST_CH + 1;
    localparam int ST_ACC     = ST_MUL + 1;
    localparam int ST_OUT     = ST_ACC + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef logic signed [SUM_W-1:0]  chan_t;
    typedef logic        [WGT_W-1:0]  wgt_t;
    typedef logic        [ROW_W-1:0]  row_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_RED   = 2'd0,
        CFG_ROW_GREEN = 2'd1,
        CFG_ROW_BLUE  = 2'd2
    } cfg_index_t;

    localparam row_t ROW_RED_RST   = 54'd16384;
    localparam row_t ROW_GREEN_RST = 54'd4294967296;
    localparam row_t ROW_BLUE_RST  = 54'd1125899906842624;

    localparam chan_t CHAN_MAX = 32'sh7FFF_FFFF;
    localparam chan_t CHAN_MIN = 32'sh8000_0000;
    localparam acc_t  ROUND_HALF = 52'sd8192;

endpackage

`default_nettype wire

>>> hw/rtl/weighted_pixel_normalize_color_matrix.sv
// Weighted pixel normalize and 3x3 color matrix.
//
// Input stream (s_*): one beat per pixel carrying three signed Q16.16 color
// sums and an unsigned Q8.16 blend weight. Each sum is divided by the weight
// (zero weight gives zero channels), then a 3x3 matrix of signed Q3.14
// coefficients maps the channels to three saturated signed Q16.16 outputs on
// the output stream (m_*).
// Configuration (cfg_*): index 0..2 selects the red, green or blue matrix row;
// cfg_ready is always high. Write only while no pixel is in flight.
// Throughput is one pixel per clock while the receiver is not stalling. The
// pipeline holds the divider, whose eight stages resolve the 32 quotient bits
// four per stage, plus input, setup, channel, multiply, sum and saturate
// stages.
// Reset clears all stage valid bits and loads the identity matrix.
// When the receiver stalls, full stages hold and empty stages ahead still
// fill, so s_tready drops only once every stage holds a pixel.
`default_nettype none

module weighted_pixel_normalize_color_matrix (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // sum_red[31:0], sum_green[63:32], sum_blue[95:64], weight_sum[119:96]
    input  wire logic [wpncm_pkg::IN_W-1:0]             s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // out_red[31:0], out_green[63:32], out_blue[95:64]
    output logic [wpncm_pkg::OUT_BUS_W-1:0]             m_tdata,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [wpncm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [wpncm_pkg::ROW_W-1:0]            cfg_data
);
    import wpncm_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_en;

    row_t  row_reg [NUM_CH];

    chan_t in_sum_reg [NUM_CH];
    wgt_t  in_wgt_reg;

    // Divider stage registers; index 0 is the setup stage
    logic [WGT_W-1:0]  rem_reg  [DIV_STAGES+1][NUM_CH];
    logic [QUO_W-1:0]  quo_reg  [DIV_STAGES+1][NUM_CH];
    wgt_t              wgt_reg  [DIV_STAGES+1];
    logic [NUM_CH-1:0] neg_reg  [DIV_STAGES+1];
    logic [NUM_CH-1:0] sat_reg  [DIV_STAGES+1];
    logic              zero_reg [DIV_STAGES+1];

    logic [WGT_W-1:0]  rem_next [DIV_STAGES+1][NUM_CH];
    logic [QUO_W-1:0]  quo_next [DIV_STAGES+1][NUM_CH];
    logic [NUM_CH-1:0] neg_next;
    logic [NUM_CH-1:0] sat_next;

    chan_t ch_reg   [NUM_CH];
    chan_t ch_next  [NUM_CH];
    prod_t prod_reg [NUM_CH][NUM_CH];
    prod_t prod_next[NUM_CH][NUM_CH];
    acc_t  acc_reg  [NUM_CH];
    acc_t  acc_next [NUM_CH];
    chan_t out_reg  [NUM_CH];
    chan_t out_next [NUM_CH];

    // Stall chain: a stage takes new data when empty or when the next one moves
    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_tready  = stage_en[ST_IN];
    assign m_tvalid  = valid_reg[ST_OUT];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_RED_RST;
            row_reg[1] <= ROW_GREEN_RST;
            row_reg[2] <= ROW_BLUE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROW_RED:   row_reg[0] <= cfg_data;
                CFG_ROW_GREEN: row_reg[1] <= cfg_data;
                CFG_ROW_BLUE:  row_reg[2] <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Setup: magnitude, sign, zero weight, and overflow of the quotient past 2^31
    always_comb
    begin : setup_comb
        logic [SUM_W-1:0] mag;
        for (int c = 0; c < NUM_CH; c++)
        begin
            neg_next[c] = in_sum_reg[c][SUM_W-1];
            mag = neg_next[c] ? SUM_W'(-in_sum_reg[c]) : SUM_W'(in_sum_reg[c]);
            sat_next[c] = {7'd0, mag} >= {in_wgt_reg, 15'd0};
            // High half seeds the remainder; it stays below the weight unless saturated
            rem_next[0][c] = {8'd0, mag[31:16]};
            quo_next[0][c] = {mag[15:0], 16'd0};
        end
    end

    // Restoring division: dividend bits shift out of quo, quotient bits shift in
    for (genvar d = 0; d < DIV_STAGES; d++)
    begin : g_div
        always_comb
        begin : div_comb
            logic [WGT_W-1:0] r;
            logic [QUO_W-1:0] q;
            logic [WGT_W:0]   t;
            logic [WGT_W:0]   diff;
            for (int c = 0; c < NUM_CH; c++)
            begin
                r = rem_reg[d][c];
                q = quo_reg[d][c];
                for (int s = 0; s < STEPS_PER_STAGE; s++)
                begin
                    t    = {r, q[QUO_W-1]};
                    q    = {q[QUO_W-2:0], 1'b0};
                    diff = t - {1'b0, wgt_reg[d]};
                    if (t >= {1'b0, wgt_reg[d]})
                    begin
                        r    = diff[WGT_W-1:0];
                        q[0] = 1'b1;
                    end
                    else
                    begin
                        r = t[WGT_W-1:0];
                    end
                end
                rem_next[d+1][c] = r;
                quo_next[d+1][c] = q;
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (zero_reg[DIV_STAGES])
            begin
                ch_next[c] = '0;
            end
            else if (sat_reg[DIV_STAGES][c])
            begin
                ch_next[c] = neg_reg[DIV_STAGES][c] ? CHAN_MIN : CHAN_MAX;
            end
            else if (neg_reg[DIV_STAGES][c])
            begin
                ch_next[c] = -chan_t'(quo_reg[DIV_STAGES][c]);
            end
            else
            begin
                ch_next[c] = chan_t'(quo_reg[DIV_STAGES][c]);
            end
        end
    end

    always_comb
    begin : mul_comb
        coef_t coef;
        for (int r = 0; r < NUM_CH; r++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                coef = coef_t'(row_reg[r][COEF_W*c +: COEF_W]);
                prod_next[r][c] = coef * ch_reg[c];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_CH; r++)
        begin
            acc_next[r] = acc_t'(prod_reg[r][0]) + acc_t'(prod_reg[r][1])
                        + acc_t'(prod_reg[r][2]) + ROUND_HALF;
        end
    end

    // Floor shift to Q16.16, then clamp to 32 bits
    always_comb
    begin : sat_comb
        logic signed [SHIFT_W-1:0] sh;
        for (int r = 0; r < NUM_CH; r++)
        begin
            sh = SHIFT_W'(acc_reg[r] >>> FRAC_SH);
            if (sh[SHIFT_W-1:OUT_W-1] == '0 || sh[SHIFT_W-1:OUT_W-1] == '1)
            begin
                out_next[r] = chan_t'(sh[OUT_W-1:0]);
            end
            else
            begin
                out_next[r] = sh[SHIFT_W-1] ? CHAN_MIN : CHAN_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_IN])
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                in_sum_reg[c] <= chan_t'(s_tdata[SUM_W*c +: SUM_W]);
            end
            in_wgt_reg <= s_tdata[NUM_CH*SUM_W +: WGT_W];
        end
        if (stage_en[ST_PREP])
        begin
            rem_reg[0]  <= rem_next[0];
            quo_reg[0]  <= quo_next[0];
            wgt_reg[0]  <= in_wgt_reg;
            neg_reg[0]  <= neg_next;
            sat_reg[0]  <= sat_next;
            zero_reg[0] <= (in_wgt_reg == '0);
        end
        for (int d = 0; d < DIV_STAGES; d++)
        begin
            if (stage_en[ST_PREP+1+d])
            begin
                rem_reg[d+1]  <= rem_next[d+1];
                quo_reg[d+1]  <= quo_next[d+1];
                wgt_reg[d+1]  <= wgt_reg[d];
                neg_reg[d+1]  <= neg_reg[d];
                sat_reg[d+1]  <= sat_reg[d];
                zero_reg[d+1] <= zero_reg[d];
            end
        end
        if (stage_en[ST_CH])
        begin
            ch_reg <= ch_next;
        end
        if (stage_en[ST_MUL])
        begin
            prod_reg <= prod_next;
        end
        if (stage_en[ST_ACC])
        begin
            acc_reg <= acc_next;
        end
        if (stage_en[ST_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = {out_reg[2], out_reg[1], out_reg[0]};

endmodule

`default_nettype wire

>>> hw/rtl/wpncm_checker.sv
`default_nettype none

module wpncm_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [wpncm_pkg::OUT_BUS_W-1:0]     m_tdata
);
    import wpncm_pkg::*;

    logic [4:0] occ_reg;
    logic [4:0] occ_next;

    always_comb
    begin
        occ_next = occ_reg + 5'(s_tvalid && s_tready) - 5'(m_tvalid && m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output data changed under stall");

    // A moving output frees every stage, so the input side must be open
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> occ_reg != 5'd0)
        else $error("output beat without a pixel in flight");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 5'(NUM_STAGES))
        else $error("more pixels in flight than stages");

endmodule

bind weighted_pixel_normalize_color_matrix wpncm_checker u_wpncm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import wpncm_pkg::*;

    typedef logic [IN_W-1:0]      pixel_beat_t;
    typedef logic [OUT_BUS_W-1:0] color_beat_t;

    typedef enum int {
        MTX_FULL,
        MTX_MAX,
        MTX_NEAR_UNITY,
        MTX_EXTREME,
        MTX_SPARSE
    } mtx_kind_t;

    typedef struct packed {
        logic [1:0] mtx;
        chan_t      red;
        chan_t      green;
        chan_t      blue;
        wgt_t       weight;
        bit         known;
        chan_t      want_red;
        chan_t      want_green;
        chan_t      want_blue;
    } pixel_case_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 115;
    localparam int NUM_PHASES  = 6;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 200;
    localparam int NUM_CASES   = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    localparam coef_t COEF_MAX = 18'sh1FFFF;
    localparam coef_t COEF_MIN = 18'sh20000;

    localparam logic [1:0] DIR_IDENTITY = 2'd0;
    localparam logic [1:0] DIR_TINY     = 2'd1;
    localparam logic [1:0] DIR_EXTREME  = 2'd2;

    // identity, one LSB on the diagonal, saturating rows
    localparam row_t DIR_MATRIX [3][3] = '{
        '{ROW_RED_RST, ROW_GREEN_RST, ROW_BLUE_RST},
        '{row_t'(1), row_t'(1) << COEF_W, row_t'(1) << (2 * COEF_W)},
        '{{3{COEF_MAX}}, {3{COEF_MIN}}, row_t'(0)}
    };

    localparam pixel_case_t PIXEL_CASES [NUM_CASES] = '{
        // zero weight gives zero regardless of the sums
        '{DIR_IDENTITY, CHAN_MAX, CHAN_MAX, CHAN_MAX, 24'h000000, 1'b1,
          32'sd0, 32'sd0, 32'sd0},
        '{DIR_IDENTITY, CHAN_MIN, CHAN_MIN, CHAN_MIN, 24'h000000, 1'b1,
          32'sd0, 32'sd0, 32'sd0},
        '{DIR_IDENTITY, 32'sh12345678, -32'sd1, 32'sd0, 24'h010000, 1'b1,
          32'sh12345678, -32'sd1, 32'sd0},
        '{DIR_IDENTITY, 32'sd1, -32'sd1, 32'sd0, 24'h000001, 1'b1,
          32'sd65536, -32'sd65536, 32'sd0},
        // normalize saturates, blue lands one past the top
        '{DIR_IDENTITY, CHAN_MAX, CHAN_MIN, 32'sh8000, 24'h000001, 1'b1,
          CHAN_MAX, CHAN_MIN, CHAN_MAX},
        '{DIR_IDENTITY, 32'sh7FFF, -32'sh8000, -32'sh8001, 24'h000001, 1'b1,
          32'sh7FFF0000, CHAN_MIN, CHAN_MIN},
        // quotient truncates toward zero
        '{DIR_IDENTITY, 32'sd3, -32'sd3, 32'sd1, 24'h020000, 1'b1,
          32'sd1, -32'sd1, 32'sd0},
        '{DIR_IDENTITY, CHAN_MIN, CHAN_MAX, 32'sh80000001, 24'h010000, 1'b1,
          CHAN_MIN, CHAN_MAX, 32'sh80000001},
        '{DIR_IDENTITY, CHAN_MAX, CHAN_MIN, 32'sh12345, 24'hFFFFFF, 1'b0,
          32'sd0, 32'sd0, 32'sd0},
        '{DIR_IDENTITY, 32'sh40000000, -32'sh40000000, 32'shA00000, 24'h800000, 1'b0,
          32'sd0, 32'sd0, 32'sd0},
        '{DIR_IDENTITY, 32'sh0F0F0F0F, 32'shF0F0F0F0, 32'sh55555555, 24'hAAAAAA, 1'b0,
          32'sd0, 32'sd0, 32'sd0},
        '{DIR_IDENTITY, 32'shF0F0F0F0, 32'sh0F0F0F0F, 32'shAAAAAAAA, 24'h555555, 1'b0,
          32'sd0, 32'sd0, 32'sd0},
        // rounding: halves go up, just below half goes down
        '{DIR_TINY, 32'sd8192, -32'sd8192, -32'sd8193, 24'h010000, 1'b1,
          32'sd1, 32'sd0, -32'sd1},
        '{DIR_TINY, 32'sd8191, 32'sd24576, -32'sd24576, 24'h010000, 1'b1,
          32'sd0, 32'sd2, -32'sd1},
        '{DIR_TINY, CHAN_MAX, CHAN_MIN, 32'sd0, 24'h010000, 1'b0,
          32'sd0, 32'sd0, 32'sd0},
        // matrix output saturates both ways
        '{DIR_EXTREME, CHAN_MAX, CHAN_MAX, CHAN_MAX, 24'h000001, 1'b1,
          CHAN_MAX, CHAN_MIN, 32'sd0},
        '{DIR_EXTREME, CHAN_MIN, CHAN_MIN, CHAN_MIN, 24'h000001, 1'b1,
          CHAN_MIN, CHAN_MAX, 32'sd0},
        '{DIR_EXTREME, 32'sd1, 32'sd0, 32'sd0, 24'h010000, 1'b0,
          32'sd0, 32'sd0, 32'sd0},
        '{DIR_EXTREME, CHAN_MAX, CHAN_MAX, CHAN_MAX, 24'h000000, 1'b1,
          32'sd0, 32'sd0, 32'sd0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // sum_red[31:0], sum_green[63:32], sum_blue[95:64], weight_sum[119:96]
    pixel_beat_t            s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // out_red[31:0], out_green[63:32], out_blue[95:64]
    color_beat_t            m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    row_t                   cfg_data;

    row_t        matrix_rows [3] = '{ROW_RED_RST, ROW_GREEN_RST, ROW_BLUE_RST};
    color_beat_t converted_pixels [$];
    int          errors  = 0;
    bit          idle_en = 1'b1;

    weighted_pixel_normalize_color_matrix DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic chan_t clamp32(input longint v);
        if (v > longint'(CHAN_MAX))
            return CHAN_MAX;
        if (v < longint'(CHAN_MIN))
            return CHAN_MIN;
        return chan_t'(v);
    endfunction

    function automatic longint normalize_sum(input chan_t sum, input wgt_t weight);
        longint s;
        longint w;
        longint mag;
        longint q;
        s   = sum;
        w   = weight;
        mag = (s < 0) ? -s : s;
        q   = (mag <<< 16) / w;
        return clamp32((s < 0) ? -q : q);
    endfunction

    function automatic chan_t mix_row(input row_t row, input longint ch [3]);
        longint acc;
        coef_t  c;
        acc = 0;
        for (int k = 0; k < NUM_CH; k++)
        begin
            c   = row[k*COEF_W +: COEF_W];
            acc = acc + longint'(c) * ch[k];
        end
        return clamp32((acc + longint'(ROUND_HALF)) >>> FRAC_SH);
    endfunction

    function automatic color_beat_t convert_pixel(input chan_t red, input chan_t green,
                                                  input chan_t blue, input wgt_t weight);
        longint ch [3];
        chan_t  sums [3];
        color_beat_t beat;
        sums = '{red, green, blue};
        for (int k = 0; k < NUM_CH; k++)
            ch[k] = (weight == '0) ? 0 : normalize_sum(sums[k], weight);
        for (int j = 0; j < NUM_CH; j++)
            beat[j*OUT_W +: OUT_W] = mix_row(matrix_rows[j], ch);
        return beat;
    endfunction

    function automatic row_t rand_row(input mtx_kind_t kind);
        row_t  row;
        coef_t c;
        for (int k = 0; k < NUM_CH; k++)
        begin
            case (kind)
                MTX_MAX:        c = COEF_MAX;
                MTX_NEAR_UNITY: c = coef_t'($urandom_range(0, 24576)) - coef_t'(8192);
                MTX_EXTREME:
                    case ($urandom_range(0, 2))
                        0:       c = COEF_MAX;
                        1:       c = COEF_MIN;
                        default: c = '0;
                    endcase
                MTX_SPARSE:     c = ($urandom_range(0, 1) != 0) ? coef_t'($urandom) : '0;
                default:        c = coef_t'($urandom);
            endcase
            row[k*COEF_W +: COEF_W] = c;
        end
        return row;
    endfunction

    function automatic chan_t rand_sum();
        case ($urandom_range(0, 7))
            0:       return CHAN_MAX;
            1:       return CHAN_MIN;
            2, 3:    return chan_t'($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
            default: return chan_t'($urandom);
        endcase
    endfunction

    function automatic wgt_t rand_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return wgt_t'($urandom_range(1, 255));
            2, 3:    return wgt_t'($urandom_range(32'h8000, 32'h3FFFF));
            default: return wgt_t'($urandom);
        endcase
    endfunction

    task automatic write_row(input logic [CFG_IDX_W-1:0] idx, input row_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ROW_RED:   matrix_rows[0] = value;
            CFG_ROW_GREEN: matrix_rows[1] = value;
            CFG_ROW_BLUE:  matrix_rows[2] = value;
            default:       ;
        endcase
    endtask

    task automatic load_matrix(input row_t red_row, input row_t green_row,
                               input row_t blue_row);
        write_row(CFG_ROW_RED, red_row);
        write_row(CFG_ROW_GREEN, green_row);
        write_row(CFG_ROW_BLUE, blue_row);
        // unused index, must leave the matrix alone
        write_row(CFG_IDX_SPARE, row_t'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input chan_t red, input chan_t green, input chan_t blue,
                              input wgt_t weight, input color_beat_t want);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19))
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {weight, blue, green, red};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        converted_pixels.push_back(want);
    endtask

    task automatic send_random_pixel();
        chan_t r;
        chan_t g;
        chan_t b;
        wgt_t  w;
        r = rand_sum();
        g = rand_sum();
        b = rand_sum();
        w = rand_weight();
        send_pixel(r, g, b, w, convert_pixel(r, g, b, w));
    endtask

    task automatic drain_pixels();
        s_tvalid <= 1'b0;
        while (converted_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_beat(input color_beat_t got);
        string       field_names [3] = '{"out_red", "out_green", "out_blue"};
        color_beat_t want;
        if (converted_pixels.size() == 0)
        begin
            $error("output beat with nothing pending: %h", got);
            errors++;
        end
        else
        begin
            want = converted_pixels.pop_front();
            for (int k = 0; k < NUM_CH; k++)
                if (got[k*OUT_W +: OUT_W] !== want[k*OUT_W +: OUT_W])
                begin
                    $error("%s: expected %0d, got %0d", field_names[k],
                           $signed(want[k*OUT_W +: OUT_W]), $signed(got[k*OUT_W +: OUT_W]));
                    errors++;
                end
        end
    endtask

    initial
    begin : rx_side
        int stall;
        int beats;
        stall = 0;
        beats = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                check_beat(m_tdata);
                beats++;
                // back up the whole pipeline once
                if (beats == HOLD_AT)
                    stall = HOLD_LEN;
            end
            if (stall == 0 && idle_en && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : tx_side
        pixel_case_t pc;
        logic [1:0]  cur_mtx;
        mtx_kind_t   kinds [NUM_PHASES];
        kinds = '{MTX_FULL, MTX_MAX, MTX_NEAR_UNITY, MTX_EXTREME, MTX_SPARSE, MTX_FULL};
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_ROW_RED;
        cfg_data  <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first rows run on the matrix left by reset
        cur_mtx = DIR_IDENTITY;
        foreach (PIXEL_CASES[i])
        begin
            pc = PIXEL_CASES[i];
            if (pc.mtx != cur_mtx)
            begin
                drain_pixels();
                load_matrix(DIR_MATRIX[pc.mtx][0], DIR_MATRIX[pc.mtx][1],
                            DIR_MATRIX[pc.mtx][2]);
                cur_mtx = pc.mtx;
            end
            send_pixel(pc.red, pc.green, pc.blue, pc.weight,
                       pc.known ? {pc.want_blue, pc.want_green, pc.want_red}
                                : convert_pixel(pc.red, pc.green, pc.blue, pc.weight));
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_pixels();
            idle_en = (p != 4 && p != NUM_PHASES - 1);
            load_matrix(rand_row(kinds[p]), rand_row(kinds[p]), rand_row(kinds[p]));
            repeat (PHASE_ITEMS)
                send_random_pixel();
        end

        drain_pixels();
        // catch any stray beat after the last one
        repeat (NUM_STAGES + 4)
            @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
